[src/sov_pkg.sv]
// ----------------------------------------------------------------------------
// sov_pkg: shared types and constants
// Phase and status codes, result record and defaults for the extractor.
// ----------------------------------------------------------------------------
package sov_pkg;

  localparam int PATTERN_BYTES_DEF = 8;
  localparam int PATTERN_W         = 64;
  localparam int OFFSET_W          = 6;
  localparam int VALUE_W           = 32;
  localparam int STATUS_W          = 2;
  localparam int LEN_W             = 4;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(19);

  // type-length byte: low nibble minus one gives the value length
  localparam logic [3:0] NIBBLE_MIN = 4'd2;
  localparam logic [3:0] NIBBLE_MAX = 4'd9;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_TYPE    = 2'd1,
    PH_COLLECT = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_PATTERN = 1'b0,
    REG_OFFSET  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                 valid;
    logic [VALUE_W-1:0]   value;
    status_t              status;
  } result_t;

endpackage

[src/sov_match.sv]
// ----------------------------------------------------------------------------
// sov_match: pattern window
// Shifts payload bytes into a window while searching and flags a full match.
// ----------------------------------------------------------------------------
module sov_match
  import sov_pkg::*;
#(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 clear,
  input  logic                 searching,
  input  logic [7:0]           data_byte,
  input  logic [PATTERN_W-1:0] pattern,
  output logic                 hit
);

  localparam int WIN_W  = 8 * PATTERN_BYTES;
  localparam int FILL_W = $clog2(PATTERN_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(PATTERN_BYTES);

  logic [WIN_W-1:0]  window;
  logic [WIN_W-1:0]  window_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  always_comb begin
    if (WIN_W > 8) begin
      window_next = {window[WIN_W-9:0], data_byte} ;
    end else begin
      window_next = WIN_W'(data_byte);
    end
    fill_next = (fill == FILL_FULL) ? fill : fill + FILL_W'(1);
  end

  assign hit = searching && (fill_next == FILL_FULL) &&
               (window_next == pattern[WIN_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (fire) begin
      if (clear) begin
        fill <= '0;
      end else if (searching) begin
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && searching) begin
      window <= window_next;
    end
  end

endmodule

[src/sov_decode.sv]
// ----------------------------------------------------------------------------
// sov_decode: value decoder
// Counts bytes from the match, reads the type-length byte and collects value.
// ----------------------------------------------------------------------------
module sov_decode
  import sov_pkg::*;
#(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                hit,
  input  logic [OFFSET_W-1:0] value_offset,
  output logic                searching,
  output phase_t              phase,
  output result_t             res
);

  localparam logic [OFFSET_W-1:0] MIN_OFF     = OFFSET_W'(PATTERN_BYTES + 1);
  localparam logic [OFFSET_W-1:0] COUNT_START = OFFSET_W'(PATTERN_BYTES - 1);

  phase_t              phase_next;
  logic [OFFSET_W-1:0] count;
  logic [OFFSET_W-1:0] count_next;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    len_next;
  logic [VALUE_W-1:0]  acc;
  logic [VALUE_W-1:0]  acc_next;
  logic [OFFSET_W-1:0] type_pos;
  logic [OFFSET_W-1:0] count_inc;
  logic [3:0]          nibble;

  assign searching = (phase == PH_SEARCH);
  assign type_pos  = ((value_offset < MIN_OFF) ? MIN_OFF : value_offset) - OFFSET_W'(1);
  assign count_inc = count + OFFSET_W'(1);
  assign nibble    = data_byte[3:0];

  always_comb begin
    phase_next = phase;
    count_next = count;
    len_next   = len;
    acc_next   = acc;
    res        = '{valid: 1'b0, value: '0, status: ST_OK};
    unique case (phase)
      PH_SEARCH: begin
        if (hit) begin
          phase_next = PH_TYPE;
          count_next = COUNT_START;
        end
      end
      PH_TYPE: begin
        count_next = count_inc;
        if (count_inc == type_pos) begin
          if (nibble < NIBBLE_MIN || nibble > NIBBLE_MAX) begin
            res.valid  = 1'b1;
            res.status = ST_BAD_LEN;
            phase_next = PH_DONE;
          end else begin
            len_next   = nibble - LEN_W'(1);
            acc_next   = '0;
            count_next = '0;
            phase_next = PH_COLLECT;
          end
        end
      end
      PH_COLLECT: begin
        acc_next   = {acc[VALUE_W-9:0], data_byte};
        count_next = count_inc;
        if (count_inc >= OFFSET_W'(len)) begin
          res.valid  = 1'b1;
          res.status = ST_OK;
          if (len == LEN_W'(1) && data_byte[7]) begin
            res.value = {{(VALUE_W-8){1'b1}}, data_byte};
          end else begin
            res.value = acc_next;
          end
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (last_byte && !res.valid && phase_next != PH_DONE) begin
      res.valid  = 1'b1;
      res.value  = '0;
      res.status = (phase_next == PH_SEARCH) ? ST_NOT_FOUND : ST_TRUNCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
    end else if (fire) begin
      phase <= last_byte ? PH_SEARCH : phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      count <= count_next;
      len   <= len_next;
      acc   <= acc_next;
    end
  end

endmodule

[src/sml_obis_value_extractor.sv]
// ----------------------------------------------------------------------------
// sml_obis_value_extractor: OBIS value extractor
// Finds an OBIS pattern in a byte stream and decodes the value that follows.
//
//   channel  | handshake          | beat
//   ---------+--------------------+------------------------------
//   in       | in_valid/in_stall  | data_byte, last_byte
//   out      | out_valid/out_stall| value, status
//   config   | APB, 64-bit data   | obis_pattern @0, value_offset @8
//
// One byte per cycle while in_stall is low; each byte is handled in the cycle it is
// accepted and a result sits in the output register the cycle after.
// At most one result per payload; a held result stalls input only while
// out_stall is high. Synchronous reset clears the parser to searching,
// pattern to zero and the offset to 19.
// ----------------------------------------------------------------------------
module sml_obis_value_extractor
  import sov_pkg::*;
#(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VALUE_W-1:0]   value,
  output logic [STATUS_W-1:0]  status,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [PATTERN_W-1:0] pwdata,
  output logic [PATTERN_W-1:0] prdata,
  output logic                 pready
);

  logic [PATTERN_W-1:0] obis_pattern;
  logic [OFFSET_W-1:0]  value_offset;
  logic                 fire;
  logic                 hit;
  logic                 searching;
  phase_t               phase;
  result_t              res;
  reg_idx_t             reg_sel;

  assign pready   = 1'b1;
  assign reg_sel  = reg_idx_t'(paddr[3]);
  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      obis_pattern <= '0;
      value_offset <= OFFSET_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_PATTERN: obis_pattern <= pwdata;
        REG_OFFSET:  value_offset <= pwdata[OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN: prdata = obis_pattern;
      REG_OFFSET:  prdata = PATTERN_W'(value_offset);
      default:     prdata = '0;
    endcase
  end

  sov_match #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_match (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .clear    (last_byte),
    .searching(searching),
    .data_byte(data_byte),
    .pattern  (obis_pattern),
    .hit      (hit)
  );

  sov_decode #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .hit         (hit),
    .value_offset(value_offset),
    .searching   (searching),
    .phase       (phase),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      value  <= res.value;
      status <= res.status;
    end
  end

  a_value_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == '0)
    else $error("nonzero value with error status");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_last_clears_phase: assert property (@(posedge clk) disable iff (rst)
    fire && last_byte |=> phase == PH_SEARCH)
    else $error("parser not back to searching after final byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && last_byte && phase != PH_DONE |=> out_valid)
    else $error("payload ended without a result");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sml_obis_value_extractor
// Feeds meter payloads byte by byte (directed frames, then random frames,
// truncated frames, noise and payloads left open across offset changes),
// predicts each reading from a local model of the parser, and compares every
// output beat field by field with the oldest predicted reading. Both channels
// idle at random; once the output is held off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top
  import sov_pkg::*;
();

  localparam int PB = PATTERN_BYTES_DEF;
  localparam logic [63:0] PAT_MASK = {64{1'b1}} >> (64 - 8 * PB);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } meter_byte_t;

  typedef struct {
    logic [31:0] value;
    status_t     status;
  } reading_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = 8'd0;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VALUE_W-1:0]   value;
  logic [STATUS_W-1:0]  status;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [3:0]           paddr = 4'd0;
  logic [PATTERN_W-1:0] pwdata = '0;
  logic [PATTERN_W-1:0] prdata;
  logic                 pready;

  sml_obis_value_extractor u_dut (.*);

  always #4 clk = ~clk;

  meter_byte_t byte_q[$];
  reading_t    reading_q[$];
  int          n_queued = 0;
  int          n_frames = 0;
  int          n_in = 0;
  int          n_errors = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // parser model: configuration and state
  logic [63:0] cfg_pattern = 64'd0;
  logic [5:0]  cfg_offset = OFFSET_RESET;
  logic [63:0] win = 64'd0;
  logic [3:0]  fill = 4'd0;
  phase_t      ph = PH_SEARCH;
  logic [5:0]  pos = 6'd0;
  logic [3:0]  vlen = 4'd0;
  logic [31:0] acc = 32'd0;

  function automatic logic [5:0] eff_offset();
    return (cfg_offset < 6'(PB + 1)) ? 6'(PB + 1) : cfg_offset;
  endfunction

  task automatic extract_reading(input logic [7:0] b, input logic lst);
    bit          hit;
    logic [31:0] rv;
    status_t     rs;
    logic [7:0]  tl;
    hit = 1'b0;
    rv = 32'd0;
    rs = ST_OK;
    case (ph)
      PH_SEARCH: begin
        win = {win[55:0], b};
        if (fill < 4'd8) fill = fill + 4'd1;
        if (fill >= PB && ((win ^ cfg_pattern) & PAT_MASK) == 64'd0) begin
          ph = PH_TYPE;
          pos = 6'(PB - 1);
        end
      end
      PH_TYPE: begin
        pos = pos + 6'd1;
        if (pos == eff_offset() - 6'd1) begin
          tl = {4'd0, b[3:0]} - 8'd1;
          if (tl < 8'd1 || tl > 8'd8) begin
            hit = 1'b1;
            rs = ST_BAD_LEN;
            ph = PH_DONE;
          end else begin
            vlen = tl[3:0];
            acc = 32'd0;
            pos = 6'd0;
            ph = PH_COLLECT;
          end
        end
      end
      PH_COLLECT: begin
        acc = {acc[23:0], b};
        pos = pos + 6'd1;
        if (pos >= vlen) begin
          hit = 1'b1;
          rv = (vlen == 4'd1 && b[7]) ? {24'hFFFFFF, b} : acc;
          rs = ST_OK;
          ph = PH_DONE;
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (!hit && ph != PH_DONE) begin
        hit = 1'b1;
        rv = 32'd0;
        rs = (ph == PH_SEARCH) ? ST_NOT_FOUND : ST_TRUNCATED;
      end
      win = 64'd0;
      fill = 4'd0;
      ph = PH_SEARCH;
      pos = 6'd0;
      vlen = 4'd0;
      acc = 32'd0;
    end
    if (hit) reading_q.push_back('{value: rv, status: rs});
  endtask

  // input driver
  always @(posedge clk) begin : drv
    meter_byte_t nb;
    bit          gaps;
    if (rst) begin
      in_valid <= 1'b0;
      data_byte <= 8'd0;
      last_byte <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        extract_reading(data_byte, last_byte);
        n_in++;
      end
      gaps = !(n_in >= 900 && n_in < 1100);
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && !(gaps && $urandom_range(0, 99) < 31)) begin
          nb = byte_q.pop_front();
          data_byte <= nb.data;
          last_byte <= nb.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stall
  always @(posedge clk) begin : mon
    reading_t r;
    bit       gaps;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reading_q.size() == 0) begin
          $error("unexpected beat: value=%h status=%0d", value, status);
          n_errors++;
        end else begin
          r = reading_q.pop_front();
          if (value !== r.value) begin
            $error("value: expected %h, got %h", r.value, value);
            n_errors++;
          end
          if (status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, status);
            n_errors++;
          end
        end
      end
      gaps = !(n_in >= 900 && n_in < 1100);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_in >= 400) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps && ($urandom_range(0, 99) < 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(int'(idx) * 8);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_PATTERN) cfg_pattern = v;
    else cfg_offset = v[5:0];
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || reading_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic lst);
    byte_q.push_back('{data: b, last: lst});
    n_queued++;
    if (lst) n_frames++;
  endtask

  task automatic push_pattern();
    for (int k = PB - 1; k >= 0; k--) push_byte(cfg_pattern[8*k +: 8], 1'b0);
  endtask

  task automatic queue_frame(input bit leave_open);
    int         kind;
    int         len;
    int         total;
    int         nib;
    logic [7:0] tl;
    logic [7:0] frame[$];
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      repeat ($urandom_range(0, 6)) frame.push_back(8'($urandom));
      for (int k = PB - 1; k >= 0; k--) frame.push_back(cfg_pattern[8*k +: 8]);
      repeat (int'(eff_offset()) - 1 - PB) frame.push_back(8'($urandom));
      len = $urandom_range(1, 8);
      tl = 8'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        tl[3:0] = 4'(len + 1);
      end else begin
        nib = $urandom_range(0, 7);
        tl[3:0] = 4'((nib < 2) ? nib : nib + 8);
      end
      frame.push_back(tl);
      repeat (len) frame.push_back(8'($urandom));
      repeat ($urandom_range(0, 4)) frame.push_back(8'($urandom));
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom));
    end else begin
      // pattern broken off part way, or at most complete
      for (int k = PB - 1; k >= PB - int'($urandom_range(1, PB)); k--)
        frame.push_back(cfg_pattern[8*k +: 8]);
      repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
    end
    total = frame.size();
    if ($urandom_range(0, 99) < 12) total = $urandom_range(1, frame.size());
    for (int k = 0; k < total; k++) push_byte(frame[k], !leave_open && k == total - 1);
  endtask

  initial begin : stim
    int          phase_idx;
    int          r;
    logic [63:0] pat;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: lone byte, no match
    push_byte(8'h00, 1'b1);
    wait_idle();

    // offset below the pattern length clamps to just after it
    write_reg(REG_PATTERN, 64'h7707_0100_0108_00FF);
    write_reg(REG_OFFSET, 64'd0);
    push_pattern();
    push_byte(8'h52, 1'b0);
    push_byte(8'h80, 1'b1);
    push_pattern();
    push_byte(8'hF0, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    phase_idx = 0;
    while (n_queued < 1400 || n_frames < 60) begin
      wait_idle();
      if (phase_idx == 2) write_reg(REG_OFFSET, 64'($urandom_range(0, 10)));
      else if (phase_idx == 3) write_reg(REG_OFFSET, 64'd63);
      else if (phase_idx == 4) write_reg(REG_OFFSET, 64'd9);
      else if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) write_reg(REG_OFFSET, 64'd63);
        else if (r == 1) write_reg(REG_OFFSET, 64'($urandom_range(0, 8)));
        else write_reg(REG_OFFSET, 64'($urandom_range(9, 40)));
      end
      if (phase_idx == 0 || phase_idx == 5 || $urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 9);
        pat = {$urandom, $urandom};
        if (phase_idx == 5 || r == 0) pat = 64'd0;
        else if (phase_idx == 0 || r == 1) pat = {64{1'b1}};
        write_reg(REG_PATTERN, pat);
      end
      repeat ($urandom_range(1, 6)) queue_frame(1'b0);
      if (phase_idx == 1) begin
        // payload left open past the match; offset then drops below the count
        push_pattern();
        repeat (3) push_byte(8'($urandom), 1'b0);
      end else if ($urandom_range(0, 9) == 0) begin
        queue_frame(1'b1);
      end
      phase_idx++;
    end
    while (byte_q.size() != 0 || in_valid || reading_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (n_errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sml_obis_value_extractor.f]
src/sov_pkg.sv
src/sov_match.sv
src/sov_decode.sv
src/sml_obis_value_extractor.sv
bench/tb_top.sv
